// File: rtl/core/linear_probe_value_set_assert.svh
// assertion macros shared by the value set rtl
// expects i_clk and i_rst_n in the including module
`ifndef LINEAR_PROBE_VALUE_SET_ASSERT_SVH
`define LINEAR_PROBE_VALUE_SET_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpvs assertion failed");

// next-cycle implication, checked outside reset
`define LPVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpvs assertion failed");

`endif

// File: rtl/core/lpvs_pkg.sv
// package for the linear probe value set: sizes, codes, request types
// no dependencies
package lpvs_pkg;

    localparam int SLOTS       = 1024;
    localparam int PROBE_LIMIT = 8;
    localparam int VALUE_BITS  = 32;
    localparam int INDEX_BITS  = 16;

    localparam int ADDR_W   = $clog2(SLOTS);
    localparam int CNT_W    = 11;
    localparam int PROBE_W  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int BIT_W    = $clog2(INDEX_BITS);
    localparam int CFG_ADDR_W = 3;
    localparam int APB_W    = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] SLOTS_RST  = CNT_W'(SLOTS);

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        OUT_REJECT = 2'd0,
        OUT_STORED = 2'd1,
        OUT_MATCH  = 2'd2,
        OUT_LIMIT  = 2'd3
    } t_outcome;

    typedef enum logic [0:0] {
        REG_SLOTS_IN_USE = 1'b0,
        REG_NONE         = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_MOD   = 2'd2,
        ST_PROBE = 2'd3
    } t_state;

    typedef struct packed {
        logic                  kind;
        logic [INDEX_BITS-1:0] index_word;
        logic [VALUE_BITS-1:0] item_value;
    } t_lpvs_req;

    typedef struct packed {
        logic             success;
        logic [1:0]       outcome;
        logic [CNT_W-1:0] element_total;
    } t_lpvs_rsp;

endpackage

// File: rtl/core/lpvs_ram.sv
// generic simple dual port ram, one write and one read port, registered read
// no dependencies
module lpvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/linear_probe_value_set.sv
// top level of the linear probe value set: control, modulo unit, apb register
// depends on lpvs_pkg, lpvs_ram and linear_probe_value_set_assert.svh
//
// usage
//   request channel: drive i_cmd and raise start; the request is taken at a
//   clock edge where start is high and busy is low. kind selects insert or
//   lookup, index_word picks the start slot, item_value is the value.
//   result channel: o_done is high for exactly one cycle with o_rsp valid;
//   the receiver cannot stall, so it must take the result in that cycle.
//   config: apb port, one register (slots_in_use) at byte address 0, pready
//   tied high; write only while busy is low and no result is pending.
// timing
//   start slot = index_word mod slots, by a restoring remainder unit that
//   takes one index bit per cycle. each probe then reads one slot through
//   the slot ram read port, 1 to 8 probes per request.
//   a nonzero request gives o_done once the remainder and probes are done,
//   and busy drops in the same cycle. a zero value is rejected with o_done in
//   the next cycle and busy never rises.
// reset
//   i_rst_n is synchronous, active low. after reset the block sweeps the
//   slot ram to zero, one slot per cycle with busy high;
//   config writes are taken during the sweep.
module linear_probe_value_set (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  lpvs_pkg::t_lpvs_req           i_cmd,
    // result channel
    output logic                          o_done,
    output lpvs_pkg::t_lpvs_rsp           o_rsp,
    // apb config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpvs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lpvs_pkg::APB_W-1:0]    pwdata,
    output logic [lpvs_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);

    import lpvs_pkg::*;

    `include "linear_probe_value_set_assert.svh"

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_slots;

    // per-request working registers
    logic                  r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [INDEX_BITS-1:0] r_idx, n_idx;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [PROBE_W-1:0]    r_probe, n_probe;
    t_lpvs_rsp             r_rsp, n_rsp;

    // slot ram interface
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;

    // helpers
    logic [CNT_W-1:0]  eff_slots;
    logic [CNT_W-1:0]  mod_trial;
    logic [ADDR_W-1:0] mod_rem;
    logic [CNT_W-1:0]  pos_inc;
    logic [ADDR_W-1:0] next_pos;
    logic              cfg_wr;

    // slots_in_use clamped to 1..SLOTS
    always_comb begin
        if (r_slots == '0) begin
            eff_slots = CNT_W'(1);
        end else if (r_slots > CNT_W'(SLOTS)) begin
            eff_slots = CNT_W'(SLOTS);
        end else begin
            eff_slots = r_slots;
        end
    end

    // one restoring step: shift in the next index bit, subtract if it fits
    assign mod_trial = {r_pos, r_idx[INDEX_BITS-1]};
    always_comb begin
        if (mod_trial >= r_n) begin
            mod_rem = ADDR_W'(mod_trial - r_n);
        end else begin
            mod_rem = ADDR_W'(mod_trial);
        end
    end

    // linear probe step with wraparound at the slots in use
    assign pos_inc  = CNT_W'({1'b0, r_pos}) + CNT_W'(1);
    assign next_pos = (pos_inc >= r_n) ? '0 : ADDR_W'(pos_inc);

    // next state and ram control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_kind    = r_kind;
        n_val     = r_val;
        n_idx     = r_idx;
        n_bit     = r_bit;
        n_n       = r_n;
        n_pos     = r_pos;
        n_probe   = r_probe;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        ram_re    = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                // zero sweep of the slot ram after reset
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_kind  = i_cmd.kind;
                    n_val   = i_cmd.item_value;
                    n_idx   = i_cmd.index_word;
                    n_bit   = BIT_W'(INDEX_BITS - 1);
                    n_n     = eff_slots;
                    n_pos   = '0;
                    if (i_cmd.item_value == '0) begin
                        // zero value: rejected at once, state untouched
                        n_done = 1'b1;
                        n_rsp  = '{success: 1'b0, outcome: OUT_REJECT,
                                   element_total: r_count};
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                n_idx = r_idx << 1;
                n_bit = r_bit - BIT_W'(1);
                n_pos = mod_rem;
                if (r_bit == '0) begin
                    // remainder done: fetch the start slot
                    ram_re  = 1'b1;
                    n_probe = '0;
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // ram_rdata holds slot r_pos
                if (r_kind == KIND_INSERT && ram_rdata == '0) begin
                    ram_we = 1'b1;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_done  = 1'b1;
                    n_rsp   = '{success: 1'b1, outcome: OUT_STORED,
                                element_total: n_count};
                    n_state = ST_IDLE;
                end else if (ram_rdata == r_val) begin
                    n_done  = 1'b1;
                    n_rsp   = '{success: 1'b1, outcome: OUT_MATCH,
                                element_total: r_count};
                    n_state = ST_IDLE;
                end else if (r_probe == PROBE_W'(PROBE_LIMIT - 1)) begin
                    n_done  = 1'b1;
                    n_rsp   = '{success: 1'b0, outcome: OUT_LIMIT,
                                element_total: r_count};
                    n_state = ST_IDLE;
                end else begin
                    // miss: read the next slot, the write port stays idle
                    n_pos   = next_pos;
                    n_probe = r_probe + PROBE_W'(1);
                    ram_re  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_bit   <= n_bit;
        r_n     <= n_n;
        r_pos   <= n_pos;
        r_probe <= n_probe;
        r_rsp   <= n_rsp;
    end

    // slot store
    lpvs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (n_pos),
        .o_rdata (ram_rdata)
    );

    // apb register: slots_in_use, word address picked by paddr[2]
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == REG_SLOTS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_RST;
        end else if (cfg_wr) begin
            r_slots <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? APB_W'(r_slots) : '0;
    assign pready = 1'b1;

    // outputs
    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // a result is only ever shown with the engine back at idle
    `LPVS_ASSERT_SAME(a_done_idle, r_done, r_state == ST_IDLE)
    // probe-phase writes only come from inserts
    `LPVS_ASSERT_SAME(a_wr_insert, r_state == ST_PROBE && ram_we, r_kind == KIND_INSERT)
    // every slot read stays inside the slots in use
    `LPVS_ASSERT_SAME(a_rd_range, ram_re, CNT_W'(n_pos) < r_n)
    // element count only holds or steps up by one
    `LPVS_ASSERT_NEXT(a_cnt_step, 1'b1, (r_count - $past(r_count)) <= CNT_W'(1))
    // a nonzero request always starts the remainder unit
    `LPVS_ASSERT_NEXT(a_start_mod, start && !busy && i_cmd.item_value != '0, r_state == ST_MOD)

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for linear_probe_value_set: directed table, then random phases
// depends on lpvs_pkg and the block rtl; predicts each unpinned result with its own copy of the set
module tb_top;
    import lpvs_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    // the slowest run, the sweep plus the directed rows and 1700 requests, each
    // with its busy time and an idle gap, stays well under this limit
    localparam int LIMIT_CYCLES = 400000;
    // the tail outlasts any nonzero request, so this covers any straggler
    localparam int TAIL_CYCLES  = 40;
    localparam logic [CFG_ADDR_W-1:0] ADDR_SLOTS = CFG_ADDR_W'(4 * int'(REG_SLOTS_IN_USE));
    localparam logic [CFG_ADDR_W-1:0] ADDR_NONE  = CFG_ADDR_W'(4 * int'(REG_NONE));
    localparam int NUM_PHASES = 9;

    // one row of the directed table; pinned rows carry a hand-written result
    typedef struct {
        t_lpvs_req cmd;
        logic      pinned;
        t_lpvs_rsp rsp;
    } t_dir_row;

    // dut ports
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_lpvs_req             i_cmd   = '0;
    logic                  o_done;
    t_lpvs_rsp             o_rsp;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [APB_W-1:0]      pwdata  = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    // hand-written result that travels with the request, launched like start
    logic                  pin_valid = 1'b0;
    t_lpvs_rsp             pin_rsp   = '0;

    // shadow copy of the set, the element count and the slots register
    logic [VALUE_BITS-1:0] slot_copy [SLOTS];
    logic [CNT_W-1:0]      stored_count;
    logic [CNT_W-1:0]      slots_setting;

    // results still owed by the block, oldest first
    t_lpvs_rsp             pending_rsp [$];
    // inserts issued so far, reused for duplicates and lookups
    logic [INDEX_BITS-1:0] seen_index [$];
    logic [VALUE_BITS-1:0] seen_value [$];
    t_dir_row              dir_rows [$];

    int unsigned           err_count   = 0;
    int unsigned           cycle_count = 0;

    linear_probe_value_set DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog: a lost result or a stuck busy ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // apply one request to the shadow set and return the result it must give
    function automatic t_lpvs_rsp apply_set_op(t_lpvs_req req);
        t_lpvs_rsp   rsp;
        int unsigned span;
        int unsigned pos;
        rsp.success = 1'b0;
        rsp.outcome = OUT_LIMIT;
        // slots register of zero behaves as one, above the table as the table
        span = slots_setting;
        if (span == 0) span = 1;
        if (span > SLOTS) span = SLOTS;
        pos = req.index_word % span;
        if (req.item_value == '0) begin
            // zero value: rejected for both kinds, set untouched
            rsp.outcome = OUT_REJECT;
        end else begin
            for (int p = 0; p < PROBE_LIMIT; p++) begin
                if (t_kind'(req.kind) == KIND_INSERT && slot_copy[pos] == '0) begin
                    slot_copy[pos] = req.item_value;
                    if (stored_count != COUNT_MAX) stored_count++;
                    rsp.success = 1'b1;
                    rsp.outcome = OUT_STORED;
                    break;
                end
                // a lookup walks past empty slots, only a match or the probe limit stops it
                if (slot_copy[pos] == req.item_value) begin
                    rsp.success = 1'b1;
                    rsp.outcome = OUT_MATCH;
                    break;
                end
                pos++;
                if (pos >= span) pos = 0;
            end
        end
        rsp.element_total = stored_count;
        return rsp;
    endfunction

    // result check first, then record the request taken at this same edge
    always @(posedge i_clk) begin
        t_lpvs_rsp want;
        t_lpvs_rsp predicted;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: result with no request waiting, %s=%0d outcome=%0d total=%0d",
                             $time, "got success", o_rsp.success, o_rsp.outcome,
                             o_rsp.element_total);
                    err_count++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.success !== want.success || o_rsp.outcome !== want.outcome ||
                        o_rsp.element_total !== want.element_total) begin
                        $display("%0t: expected success=%0d outcome=%0d total=%0d,",
                                 $time, want.success, want.outcome, want.element_total);
                        $display("%0t: actual success=%0d outcome=%0d total=%0d",
                                 $time, o_rsp.success, o_rsp.outcome, o_rsp.element_total);
                        err_count++;
                    end
                end
            end
            if (start && !busy) begin
                // shadow state moves on even when the row is pinned
                predicted = apply_set_op(i_cmd);
                pending_rsp.push_back(pin_valid ? pin_rsp : predicted);
            end
        end
    end

    // hold the request until an edge with busy low takes it; start stays high
    task automatic issue_req(input t_lpvs_req req, input logic pin, input t_lpvs_rsp pin_val);
        start     <= 1'b1;
        i_cmd     <= req;
        pin_valid <= pin;
        pin_rsp   <= pin_val;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_burst(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // sender pause until the block owes nothing
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // setup cycle then access cycle; trailing cycle keeps psel edges apart
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SLOTS) slots_setting = data[CNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // read back the slots register and compare with the shadow copy
    task automatic apb_check_slots();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SLOTS;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CNT_W-1:0] !== slots_setting) begin
            $display("%0t: slots register expected %0d, actual %0d",
                     $time, slots_setting, prdata[CNT_W-1:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // change slots in use only with the block idle; upper data bits are noise
    task automatic set_slots(input logic [CNT_W-1:0] value);
        wait_drain();
        apb_write(ADDR_SLOTS, ($urandom & ~APB_W'(COUNT_MAX)) | APB_W'(value));
        apb_check_slots();
    endtask

    function automatic void add_row(input t_kind kind, input logic [INDEX_BITS-1:0] idx,
                                    input logic [VALUE_BITS-1:0] val, input logic pin,
                                    input logic succ, input t_outcome outc,
                                    input logic [CNT_W-1:0] total);
        t_dir_row row;
        row.cmd.kind              = kind;
        row.cmd.index_word        = idx;
        row.cmd.item_value        = val;
        row.pinned                = pin;
        row.rsp.success           = succ;
        row.rsp.outcome           = outc;
        row.rsp.element_total     = total;
        dir_rows.push_back(row);
    endfunction

    // mostly well-formed traffic: fresh inserts, repeats of earlier inserts,
    // lookups of earlier values, with some zero values and blind lookups
    function automatic t_lpvs_req make_random_req();
        t_lpvs_req   r;
        int unsigned pick;
        int unsigned h;
        pick         = $urandom_range(0, 99);
        r.kind       = KIND_INSERT;
        r.index_word = INDEX_BITS'($urandom);
        r.item_value = $urandom;
        if ($urandom_range(0, 15) == 0) r.item_value = '1;
        if (r.item_value == '0) r.item_value = 1;
        if (pick < 5) begin
            r.kind       = 1'($urandom);
            r.item_value = '0;
        end else if (pick < 45 || seen_value.size() == 0) begin
            seen_index.push_back(r.index_word);
            seen_value.push_back(r.item_value);
        end else if (pick < 95) begin
            h            = $urandom_range(0, seen_value.size() - 1);
            r.index_word = seen_index[h];
            r.item_value = seen_value[h];
            if (pick >= 70) r.kind = KIND_LOOKUP;
        end else begin
            r.kind = KIND_LOOKUP;
        end
        return r;
    endfunction

    initial begin
        int unsigned phase_slots [NUM_PHASES];
        int unsigned phase_items [NUM_PHASES];
        logic        gaps_on;
        t_lpvs_rsp   no_pin;
        // shrink to tiny ranges first, then out-of-range and odd sizes, end at full size
        phase_slots = '{2, 0, 2047, 7, 1, 1025, 300, 0, 1024};
        phase_items = '{80, 60, 300, 100, 60, 300, 200, 200, 400};
        phase_slots[7] = $urandom_range(1, 2047);
        no_pin  = '0;
        gaps_on = 1'b1;

        for (int s = 0; s < SLOTS; s++) slot_copy[s] = '0;
        stored_count  = '0;
        slots_setting = SLOTS_RST;

        // directed table, all at the reset size of 1024 slots
        add_row(KIND_INSERT, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, OUT_REJECT, 11'd0);
        add_row(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b0, OUT_REJECT, 11'd0);
        add_row(KIND_INSERT, 16'h0000, 32'h0000_0001, 1'b1, 1'b1, OUT_STORED, 11'd1);
        add_row(KIND_INSERT, 16'h0000, 32'h0000_0001, 1'b1, 1'b1, OUT_MATCH,  11'd1);
        add_row(KIND_LOOKUP, 16'h0000, 32'h0000_0001, 1'b1, 1'b1, OUT_MATCH,  11'd1);
        // same start slot after the modulo, lands one further on
        add_row(KIND_INSERT, 16'h0400, 32'hFFFF_FFFF, 1'b0, 1'b0, OUT_REJECT, '0);
        // start in the last slot, wraps to the front
        add_row(KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, OUT_REJECT, '0);
        // lookup over empty slots runs the whole probe limit
        add_row(KIND_LOOKUP, 16'h0200, 32'h1234_5678, 1'b1, 1'b0, OUT_LIMIT,  11'd2);
        add_row(KIND_INSERT, 16'hFFFF, 32'hA5A5_A5A5, 1'b0, 1'b0, OUT_REJECT, '0);
        add_row(KIND_LOOKUP, 16'h03FE, 32'hA5A5_A5A5, 1'b0, 1'b0, OUT_REJECT, '0);
        add_row(KIND_INSERT, 16'h0400, 32'h0000_0000, 1'b0, 1'b0, OUT_REJECT, '0);
        // fill one cluster up to the probe limit, then overflow it
        for (int k = 0; k < PROBE_LIMIT; k++)
            add_row(KIND_INSERT, 16'h0100, 32'h0000_0100 + k, 1'b0, 1'b0, OUT_REJECT, '0);
        add_row(KIND_INSERT, 16'h0100, 32'hDEAD_BEEF, 1'b0, 1'b0, OUT_REJECT, '0);
        add_row(KIND_LOOKUP, 16'h0100, 32'hDEAD_BEEF, 1'b0, 1'b0, OUT_REJECT, '0);
        add_row(KIND_LOOKUP, 16'h0107, 32'h0000_0107, 1'b0, 1'b0, OUT_REJECT, '0);
        add_row(KIND_INSERT, 16'h8000, 32'h8000_0000, 1'b0, 1'b0, OUT_REJECT, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the clearing sweep keeps busy high, so the first request just waits
        foreach (dir_rows[r]) begin
            issue_req(dir_rows[r].cmd, dir_rows[r].pinned, dir_rows[r].rsp);
            if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 18));
        end

        // a write past the register list must leave slots in use alone
        wait_drain();
        apb_write(ADDR_NONE, $urandom);
        apb_check_slots();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_slots(CNT_W'(phase_slots[ph]));
            if (ph == NUM_PHASES - 1) gaps_on = 1'b0;
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (ph != NUM_PHASES - 1) begin
                    // switch between idling stretches and back-to-back stretches
                    if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
                    if ($urandom_range(0, 99) == 0) wait_drain();
                    else if (gaps_on && $urandom_range(0, 3) == 0)
                        idle_burst($urandom_range(1, 18));
                end
                issue_req(make_random_req(), 1'b0, no_pin);
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
